// ----- design/rsg_pkg.sv -----
package rsg_pkg;

    localparam int MAX_ECC_DEF = 32;
    localparam int ECC_W       = 6;
    localparam int SYM_W       = 8;

    // x^8 = x^4 + x^3 + x^2 + 1 for field polynomial 0x11D
    localparam logic [SYM_W-1:0] GF_REDUCE = 8'h1D;
    localparam logic [SYM_W-1:0] GF_ONE    = 8'h01;

    typedef struct packed {
        logic clr;        // zero the carried coefficient
        logic shift;      // carried coefficient takes the current read
        logic rd_live;    // read data register holds a read from the last cycle
        logic root_load;  // root = alpha^0
        logic root_adv;   // root = root * alpha
    } mac_ctl_t;

    function automatic logic [SYM_W-1:0] gf_times2(input logic [SYM_W-1:0] a);
        logic [SYM_W-1:0] sh;
        sh = {a[SYM_W-2:0], 1'b0};
        return a[SYM_W-1] ? (sh ^ GF_REDUCE) : sh;
    endfunction

    function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                                 input logic [SYM_W-1:0] b);
        logic [SYM_W-1:0] acc;
        logic [SYM_W-1:0] aa;
        acc = '0;
        aa  = a;
        for (int bit_i = 0; bit_i < SYM_W; bit_i++)
        begin
            if (b[bit_i])
            begin
                acc = acc ^ aa;
            end
            aa = gf_times2(aa);
        end
        return acc;
    endfunction

endpackage

// ----- design/rsg_coef_mem.sv -----
module rsg_coef_mem #(
    parameter int DEPTH = rsg_pkg::MAX_ECC_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [rsg_pkg::SYM_W-1:0]  wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [rsg_pkg::SYM_W-1:0]  rd_data
);

    logic [rsg_pkg::SYM_W-1:0] mem [DEPTH];
    logic [rsg_pkg::SYM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rsg_mac.sv -----
module rsg_mac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rsg_pkg::mac_ctl_t          ctl,
    input  logic [rsg_pkg::SYM_W-1:0]  rd_data,
    output logic [rsg_pkg::SYM_W-1:0]  wr_data
);

    logic [rsg_pkg::SYM_W-1:0] root_reg;
    logic [rsg_pkg::SYM_W-1:0] prev_reg;
    logic [rsg_pkg::SYM_W-1:0] cur;

    // below the lowest entry the old polynomial reads as zero
    assign cur     = ctl.rd_live ? rd_data : '0;
    assign wr_data = cur ^ rsg_pkg::gf_mul(root_reg, prev_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= rsg_pkg::GF_ONE;
        end
        else if (ctl.root_load)
        begin
            root_reg <= rsg_pkg::GF_ONE;
        end
        else if (ctl.root_adv)
        begin
            root_reg <= rsg_pkg::gf_times2(root_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            prev_reg <= '0;
        end
        else if (ctl.shift)
        begin
            prev_reg <= cur;
        end
    end

endmodule

// ----- design/rs_generator_polynomial.sv -----
// Busy from start until the last coefficient is read out (n = ecc_count, capped at MAX_ECC).
// Each multiply pass sweeps the coefficient memory, one read-multiply-write per cycle through
// the single memory port pair. After the first strobe, results follow every cycle.
// The receiver cannot stall; a new start is taken during the final result cycle.
// rst_n clears control state asynchronously; the coefficient memory is not cleared.
module rs_generator_polynomial #(
    parameter int MAX_ECC = rsg_pkg::MAX_ECC_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rsg_pkg::ECC_W-1:0]   ecc_count,
    output logic                        strobe,
    output logic [rsg_pkg::ECC_W-1:0]   degree,
    output logic [rsg_pkg::SYM_W-1:0]   coeff_value,
    output logic                        last
);

    localparam int ECC_W = rsg_pkg::ECC_W;
    localparam int SYM_W = rsg_pkg::SYM_W;
    localparam int DEPTH = MAX_ECC + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_ECC + 2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INIT  = 2'd1;
    localparam logic [1:0] ST_BUILD = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]     state_reg,   state_next;
    logic [AW-1:0]  n_reg,       n_next;
    logic [CW-1:0]  iter_reg,    iter_next;
    logic [CW-1:0]  step_reg,    step_next;
    logic [AW-1:0]  emit_reg,    emit_next;
    logic           rd_live_reg;
    logic           out_valid_reg, out_valid_next;
    logic [AW-1:0]  degree_reg,  degree_next;
    logic           last_reg,    last_next;

    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [SYM_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [SYM_W-1:0] mem_rd_data;
    logic [SYM_W-1:0] mac_out;
    rsg_pkg::mac_ctl_t mac_ctl;

    logic [CW-1:0]  rd_off;
    logic [CW-1:0]  wr_off;
    logic           iter_done;
    logic           last_iter;

    assign rd_off    = iter_reg - step_reg;
    assign wr_off    = iter_reg + CW'(2) - step_reg;
    assign iter_done = (step_reg == iter_reg + CW'(2));
    assign last_iter = (iter_reg + CW'(1) == CW'(n_reg));

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        iter_next      = iter_reg;
        step_next      = step_reg;
        emit_next      = emit_reg;
        out_valid_next = 1'b0;
        degree_next    = degree_reg;
        last_next      = last_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = wr_off[AW-1:0];
        mem_wr_data    = mac_out;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = rd_off[AW-1:0];
        mac_ctl        = '0;
        mac_ctl.rd_live = rd_live_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (ecc_count > ECC_W'(MAX_ECC))
                    begin
                        n_next = AW'(MAX_ECC);
                    end
                    else
                    begin
                        n_next = ecc_count[AW-1:0];
                    end
                    mac_ctl.root_load = 1'b1;
                    state_next        = ST_INIT;
                end
            end
            ST_INIT:
            begin
                // polynomial starts as the constant 1
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = rsg_pkg::GF_ONE;
                iter_next   = '0;
                step_next   = '0;
                emit_next   = n_reg;
                state_next  = (n_reg == '0) ? ST_EMIT : ST_BUILD;
            end
            ST_BUILD:
            begin
                // read old[i-c], write new[i+2-c] = old[i+1-c] ^ root*old[i+2-c]
                mem_rd_en     = (step_reg <= iter_reg);
                mem_wr_en     = (step_reg != '0);
                mac_ctl.clr   = (step_reg == '0);
                mac_ctl.shift = (step_reg != '0);
                if (iter_done)
                begin
                    mac_ctl.root_adv = 1'b1;
                    step_next        = '0;
                    iter_next        = iter_reg + CW'(1);
                    if (last_iter)
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                mem_rd_en      = 1'b1;
                mem_rd_addr    = emit_reg;
                out_valid_next = 1'b1;
                degree_next    = emit_reg;
                last_next      = (emit_reg == '0);
                if (emit_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit_next = emit_reg - AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            step_reg      <= '0;
            emit_reg      <= '0;
            rd_live_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            step_reg      <= step_next;
            emit_reg      <= emit_next;
            rd_live_reg   <= mem_rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        degree_reg <= degree_next;
        last_reg   <= last_next;
    end

    rsg_coef_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rsg_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .rd_data (mem_rd_data),
        .wr_data (mac_out)
    );

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = out_valid_reg;
    assign degree      = ECC_W'(degree_reg);
    assign coeff_value = mem_rd_data;
    assign last        = last_reg;

endmodule

// ----- design/rsg_checker.sv -----
module rsg_props (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        strobe,
    input logic [rsg_pkg::ECC_W-1:0]   degree,
    input logic [rsg_pkg::SYM_W-1:0]   coeff_value,
    input logic                        last
);

    // an accepted transaction keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after accepted start");

    // results of one run come on consecutive cycles with degree counting down
    a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && (degree == $past(degree) - 1'b1))
        else $error("coefficient run broken or degree out of order");

    // generator polynomial is monic
    a_leading_one: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !$past(strobe) |-> coeff_value == rsg_pkg::GF_ONE)
        else $error("leading coefficient is not one");

    // constant term is a product of nonzero roots
    a_const_term: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> (degree == '0) && (coeff_value != '0))
        else $error("bad constant term");

    a_no_idle_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("result strobe while idle");

endmodule

bind rs_generator_polynomial rsg_props u_rsg_checker (.*);
